// File: rtl/core/cluster_bitmap_allocator_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH
`define CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cba_pkg.sv
`default_nettype none

package cba_pkg;

  localparam int CLUSTER_TOTAL_DEF = 243;

  localparam int CL_W        = 8;
  localparam int CNT_W       = 8;
  localparam int BYTE_IX_W   = CL_W - 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [7:0] FULL_BYTE     = 8'hFF;
  localparam logic [7:0] RESERVED_BITS = 8'h03;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_MARK    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic alloc_stop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/cba_ctrl.sv
`default_nettype none

module cba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire cba_pkg::sts_t sts,
  output cba_pkg::cmd_t      cmd
);

`include "cluster_bitmap_allocator_macros.svh"

  cba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      cba_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = cba_pkg::ST_EXEC;
        end
      end
      cba_pkg::ST_EXEC: begin
        if (sts.op != cba_pkg::OP_ALLOC || sts.alloc_stop) begin
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = cba_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = cba_pkg::ST_IDLE;
    endcase
  end

  `CBA_ASSERT_IMP(a_step_only_alloc, cmd.step, sts.op == cba_pkg::OP_ALLOC, "scan step outside allocate")
  `CBA_ASSERT_NXT(a_load_then_exec, cmd.load, state_r == cba_pkg::ST_EXEC && !in_tready, "accept did not start execution")

endmodule

`default_nettype wire

// File: rtl/core/cba_dpath.sv
`default_nettype none

module cba_dpath #(
  parameter int CLUSTER_TOTAL = cba_pkg::CLUSTER_TOTAL_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [cba_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire cba_pkg::cmd_t                    cmd,
  output cba_pkg::sts_t                         sts,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [cba_pkg::OUT_TDATA_W-1:0]       out_tdata
);

`include "cluster_bitmap_allocator_macros.svh"

  localparam int MAP_BYTES = (CLUSTER_TOTAL + 7) / 8;
  localparam int IDX_W     = $clog2(MAP_BYTES);
  localparam logic [cba_pkg::CL_W-1:0]  TOTAL_C = cba_pkg::CL_W'(CLUSTER_TOTAL);
  localparam logic [cba_pkg::CNT_W-1:0] START_CNT = cba_pkg::CNT_W'(CLUSTER_TOTAL - 2);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(MAP_BYTES - 1);

  logic [7:0]               map_r   [MAP_BYTES];
  logic [7:0]               map_nxt [MAP_BYTES];
  logic [cba_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  cba_pkg::op_t             op_r, op_nxt;
  logic [cba_pkg::CL_W-1:0] cl_r, cl_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [cba_pkg::CL_W-1:0] granted_r, granted_nxt;
  logic                     ok_r, ok_nxt;

  logic [IDX_W-1:0]         addr;
  logic [7:0]               rd_byte;
  logic [2:0]               zpos;
  logic                     has_zero;
  logic [cba_pkg::CL_W-1:0] cand;
  logic                     cand_ok;
  logic                     scan_fail;
  logic                     cl_valid;
  logic                     cl_used;
  logic [2:0]               wr_pos;

  assign cl_valid = (cl_r >= cba_pkg::CL_W'(2)) && (cl_r < TOTAL_C);

  always_comb begin
    if (op_r == cba_pkg::OP_ALLOC) begin
      addr = idx_r;
    end else if (cl_valid) begin
      addr = cl_r[3 +: IDX_W];
    end else begin
      addr = '0;
    end
  end

  assign rd_byte  = map_r[addr];
  assign has_zero = (rd_byte != cba_pkg::FULL_BYTE);
  assign cl_used  = rd_byte[cl_r[2:0]];

  always_comb begin
    zpos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rd_byte[i]) zpos = 3'(i);
    end
  end

  assign cand      = {cba_pkg::BYTE_IX_W'(idx_r), zpos};
  assign cand_ok   = has_zero && (cand < TOTAL_C);
  assign scan_fail = has_zero ? !cand_ok : (idx_r == LAST_IX);

  assign sts.op         = op_r;
  assign sts.alloc_stop = (cnt_r == '0) || cand_ok || scan_fail;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign wr_pos = (op_r == cba_pkg::OP_ALLOC) ? zpos : cl_r[2:0];

  always_comb begin
    map_nxt       = map_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    cl_nxt        = cl_r;
    idx_nxt       = idx_r;
    granted_nxt   = granted_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cmd.load) begin
      op_nxt  = cba_pkg::op_t'(in_tdata[1:0]);
      cl_nxt  = in_tdata[2 +: cba_pkg::CL_W];
      idx_nxt = '0;
    end
    if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      granted_nxt   = '0;
      ok_nxt        = 1'b0;
      case (op_r)
        cba_pkg::OP_START: begin
          for (int b = 0; b < MAP_BYTES; b++) map_nxt[b] = 8'h00;
          map_nxt[0] = cba_pkg::RESERVED_BITS;
          cnt_nxt    = START_CNT;
          ok_nxt     = 1'b1;
        end
        cba_pkg::OP_ALLOC: begin
          if (cnt_r != '0 && cand_ok) begin
            map_nxt[addr][wr_pos] = 1'b1;
            cnt_nxt     = cnt_r - cba_pkg::CNT_W'(1);
            granted_nxt = cand;
            ok_nxt      = 1'b1;
          end
        end
        cba_pkg::OP_MARK: begin
          if (cl_valid && !cl_used) begin
            map_nxt[addr][wr_pos] = 1'b1;
            if (cnt_r != '0) cnt_nxt = cnt_r - cba_pkg::CNT_W'(1);
            ok_nxt = 1'b1;
          end
        end
        default: begin
          if (cl_valid && cl_used) begin
            map_nxt[addr][wr_pos] = 1'b0;
            if (cnt_r != cba_pkg::CNT_MAX) cnt_nxt = cnt_r + cba_pkg::CNT_W'(1);
            ok_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAP_BYTES; b++) map_r[b] <= 8'h00;
      map_r[0]    <= cba_pkg::RESERVED_BITS;
      cnt_r       <= START_CNT;
      out_valid_r <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cl_r      <= cl_nxt;
    idx_r     <= idx_nxt;
    granted_r <= granted_nxt;
    ok_r      <= ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, cnt_r, ok_r, granted_r};

  `CBA_ASSERT_IMP(a_commit_slot_free, cmd.commit, !out_valid_r || out_tready, "result overwritten")
  `CBA_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_r, "committed result not presented")
  `CBA_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= START_CNT, "free count above cluster total")
  `CBA_ASSERT_IMP(a_reserved_kept, 1'b1, map_r[0][1:0] == 2'b11, "directory clusters freed")

endmodule

`default_nettype wire

// File: rtl/core/cluster_bitmap_allocator.sv
// Start, mark used and release load the request, then commit once the output slot is free.
// Allocate scans one bitmap byte per cycle until it grants a cluster, runs off the map or sees no free count.
// Throughput: one transaction executes at a time; the next is accepted once the result registers.
// Reset (rst_n low, synchronous): bitmap holds only clusters 0 and 1, free count is
// CLUSTER_TOTAL-2, no result pending.
`default_nettype none

module cluster_bitmap_allocator #(
  parameter int CLUSTER_TOTAL = cba_pkg::CLUSTER_TOTAL_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [1:0] opcode, [9:2] cluster_number
  input  wire logic [cba_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [7:0] granted_cluster, [8] ok, [16:9] free_clusters
  output logic [cba_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  cba_pkg::cmd_t cmd;
  cba_pkg::sts_t sts;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_dpath #(
    .CLUSTER_TOTAL (CLUSTER_TOTAL)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
